[hw/rtl/u8c_pkg.sv]
// Shared types and constants for the six-byte UTF-8 codec.
// Used by every module of the codec; depends on nothing else.
package u8c_pkg;

    localparam int CP_W            = 31;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 3;
    localparam int STREAM_W        = 40;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] LEAD_2    = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_5    = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_6    = 8'hFC;
    localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;

    localparam logic [CP_W-1:0] MAX_1 = 31'h7F;
    localparam logic [CP_W-1:0] MAX_2 = 31'h7FF;
    localparam logic [CP_W-1:0] MAX_3 = 31'hFFFF;
    localparam logic [CP_W-1:0] MAX_4 = 31'h1FFFFF;
    localparam logic [CP_W-1:0] MAX_5 = 31'h3FFFFFF;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef enum logic {
        KIND_BYTE       = 1'b0,
        KIND_CODE_POINT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  len;
        logic [CP_W-1:0]   value;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic empty;
        job_t head;
    } q_rd_t;

endpackage

[hw/rtl/u8c_front.sv]
// Front end of the codec: accepts input transfers, keeps the decode state and
// turns each item into at most one job for the queue. Depends on u8c_pkg.
module u8c_front
    import u8c_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    input  logic [CP_W-1:0]      in_code_point,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 q_full,
    output q_wr_t                q_wr
);

    logic [LEN_W-1:0] pending_reg;
    logic [LEN_W-1:0] pending_next;
    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic             accept;
    logic [LEN_W-1:0] pending_dec;
    logic [CP_W-1:0]  shifted;

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign pending_dec = pending_reg - LEN_W'(1);
    assign shifted     = {partial_reg[CP_W-7:0], in_byte[5:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            partial_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

    always_comb
    begin
        pending_next     = pending_reg;
        partial_next     = partial_reg;
        q_wr.push        = 1'b0;
        q_wr.job.kind    = KIND_CODE_POINT;
        q_wr.job.len     = LEN_W'(1);
        q_wr.job.value   = CP_W'(in_byte);
        if (accept)
        begin
            if (op_t'(in_op) == OP_ENCODE)
            begin
                q_wr.push      = 1'b1;
                q_wr.job.kind  = KIND_BYTE;
                q_wr.job.value = in_code_point;
                priority if (in_code_point <= MAX_1) q_wr.job.len = LEN_W'(1);
                else if (in_code_point <= MAX_2)     q_wr.job.len = LEN_W'(2);
                else if (in_code_point <= MAX_3)     q_wr.job.len = LEN_W'(3);
                else if (in_code_point <= MAX_4)     q_wr.job.len = LEN_W'(4);
                else if (in_code_point <= MAX_5)     q_wr.job.len = LEN_W'(5);
                else                                 q_wr.job.len = LEN_W'(6);
            end
            else if (pending_reg != '0)
            begin
                pending_next   = pending_dec;
                partial_next   = shifted;
                q_wr.job.value = shifted;
                q_wr.push      = (pending_dec == '0);
            end
            else
            begin
                priority casez (in_byte)
                    8'b110?????:
                    begin
                        pending_next = LEN_W'(1);
                        partial_next = CP_W'(in_byte[4:0]);
                    end
                    8'b1110????:
                    begin
                        pending_next = LEN_W'(2);
                        partial_next = CP_W'(in_byte[3:0]);
                    end
                    8'b11110???:
                    begin
                        pending_next = LEN_W'(3);
                        partial_next = CP_W'(in_byte[2:0]);
                    end
                    8'b111110??:
                    begin
                        pending_next = LEN_W'(4);
                        partial_next = CP_W'(in_byte[1:0]);
                    end
                    8'b1111110?:
                    begin
                        pending_next = LEN_W'(5);
                        partial_next = CP_W'(in_byte[0]);
                    end
                    default:
                    begin
                        q_wr.push = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/u8c_queue.sv]
// Short job queue between the front end and the back end of the codec.
// Depends on u8c_pkg for the job type.
module u8c_queue
    import u8c_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t wr,
    output logic  full,
    input  logic  pop,
    output q_rd_t rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd.empty = (count_reg == '0);
    assign rd.head  = entries_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && !rd.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr.job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> !full)
        else $error("A job was offered to a full queue.");

endmodule

[hw/rtl/u8c_back.sv]
// Back end of the codec: takes jobs from the queue and produces result
// transfers through an output register. Depends on u8c_pkg.
module u8c_back
    import u8c_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_rd_t               rd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [BYTE_W-1:0]   out_byte,
    output logic [CP_W-1:0]     out_code_point,
    output logic                out_last
);

    logic               out_valid_reg;
    logic               out_valid_next;
    kind_t              out_kind_reg;
    kind_t              out_kind_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [BYTE_W-1:0]  out_byte_next;
    logic [CP_W-1:0]    out_cp_reg;
    logic [CP_W-1:0]    out_cp_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               busy_reg;
    logic               busy_next;
    logic [CP_W-1:0]    cp_reg;
    logic [CP_W-1:0]    cp_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [LEN_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   pos_next;
    logic               load;
    logic               busy_last;

    function automatic logic [BYTE_W-1:0] enc_byte(input logic [CP_W-1:0] cp,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] pos);
        logic [LEN_W-1:0]  grp_idx;
        logic [4:0]        sh;
        logic [CP_W-1:0]   grp;
        logic [BYTE_W-1:0] lead;
        grp_idx = len - LEN_W'(1) - pos;
        sh      = 5'(grp_idx) * 5'd6;
        grp     = cp >> sh;
        unique case (len)
            LEN_W'(2): lead = LEAD_2;
            LEN_W'(3): lead = LEAD_3;
            LEN_W'(4): lead = LEAD_4;
            LEN_W'(5): lead = LEAD_5;
            default:   lead = LEAD_6;
        endcase
        if (len == LEN_W'(1))
        begin
            return {1'b0, cp[6:0]};
        end
        else if (pos == '0)
        begin
            return lead + grp[BYTE_W-1:0];
        end
        return CONT_MARK | {2'b00, grp[5:0]};
    endfunction

    assign load           = !out_valid_reg || out_ready;
    assign busy_last      = (pos_reg == len_reg - LEN_W'(1));
    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_byte       = out_byte_reg;
    assign out_code_point = out_cp_reg;
    assign out_last       = out_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_cp_next    = out_cp_reg;
        out_last_next  = out_last_reg;
        busy_next      = busy_reg;
        cp_next        = cp_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_BYTE;
                out_byte_next  = enc_byte(cp_reg, len_reg, pos_reg);
                out_cp_next    = '0;
                out_last_next  = busy_last;
                busy_next      = !busy_last;
                pos_next       = pos_reg + LEN_W'(1);
            end
            else if (!rd.empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = rd.head.kind;
                if (rd.head.kind == KIND_CODE_POINT)
                begin
                    out_byte_next = '0;
                    out_cp_next   = rd.head.value;
                    out_last_next = 1'b1;
                end
                else
                begin
                    out_byte_next = enc_byte(rd.head.value, rd.head.len, '0);
                    out_cp_next   = '0;
                    out_last_next = (rd.head.len == LEN_W'(1));
                    busy_next     = (rd.head.len != LEN_W'(1));
                    cp_next       = rd.head.value;
                    len_next      = rd.head.len;
                    pos_next      = LEN_W'(1);
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_cp_reg   <= out_cp_next;
        out_last_reg <= out_last_next;
        cp_reg       <= cp_next;
    end

    a_decode_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_CODE_POINT) |-> out_last_reg)
        else $error("A decoded code point left without its last flag.");

    a_busy_pos: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg != '0 && pos_reg < len_reg))
        else $error("Encode byte position is out of range.");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (out_valid_reg && out_kind_reg == KIND_BYTE && !out_last_reg))
        else $error("Encode sequence in progress without a pending byte transfer.");

endmodule

[hw/rtl/utf8_six_byte_codec_top.sv]
// Top level of the six-byte UTF-8 codec: stream ports, front end, job queue
// and back end. Depends on u8c_pkg, u8c_front, u8c_queue and u8c_back.
//
// The codec accepts one input transfer per cycle while its job queue has
// room. A decode byte yields zero or one result; an encode code point yields
// one to six byte results, one per cycle while the output side is ready, so
// the output side sets the sustained rate for encode traffic. A result passes
// through a queue entry and then the output register after its input transfer.
// The queue holds QUEUE_DEPTH jobs, which is how far the input side can run
// ahead of a stalled or busy output side.
module utf8_six_byte_codec_top
    import u8c_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [STREAM_W-1:0] s_axis_tdata,   // code_point, byte_in, zero pad.
    input  logic                s_axis_tuser,   // op.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [STREAM_W-1:0] m_axis_tdata,   // byte_out, code_point_out, zero pad.
    output logic                m_axis_tuser,   // kind.
    output logic                m_axis_tlast
);

    q_wr_t              q_wr;
    q_rd_t              q_rd;
    logic               q_full;
    logic               q_pop;
    logic [BYTE_W-1:0]  out_byte;
    logic [CP_W-1:0]    out_code_point;

    u8c_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser),
        .in_code_point (s_axis_tdata[CP_W-1:0]),
        .in_byte       (s_axis_tdata[CP_W+BYTE_W-1:CP_W]),
        .q_full        (q_full),
        .q_wr          (q_wr)
    );

    u8c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rd    (q_rd)
    );

    u8c_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd             (q_rd),
        .pop            (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_kind       (m_axis_tuser),
        .out_byte       (out_byte),
        .out_code_point (out_code_point),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {{(STREAM_W - CP_W - BYTE_W){1'b0}}, out_code_point, out_byte};

endmodule
